[hdl/psfp_pkg.sv]
`default_nettype none

package psfp_pkg;

	localparam logic [7:0] HDR_FIRST   = 8'h42;
	localparam logic [7:0] HDR_SECOND  = 8'h4D;
	localparam logic [4:0] POS_PM25_HI = 5'd12;
	localparam logic [4:0] POS_PM25_LO = 5'd13;
	localparam logic [4:0] POS_PM10_HI = 5'd14;
	localparam logic [4:0] POS_PM10_LO = 5'd15;
	localparam logic [4:0] POS_CHK_HI  = 5'd30;
	localparam logic [4:0] POS_CHK_LO  = 5'd31;

	localparam int SUM_W  = 13;
	localparam int WORD_W = 16;

	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] pm10;
		logic [WORD_W-1:0] pm25;
	} psfp_result_t;

endpackage

`default_nettype wire

[hdl/psfp_core.sv]
`default_nettype none

module psfp_core
	import psfp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   rx_byte,
	output psfp_result_t      result
);

	logic [4:0]        pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [WORD_W-1:0] pm25_q;
	logic [WORD_W-1:0] pm10_q;
	logic [7:0]        chk_hi_q;

	logic [SUM_W-1:0]  sum_add;
	logic [WORD_W-1:0] check_word;

	assign sum_add    = sum_q + {{(SUM_W-8){1'b0}}, rx_byte};
	assign check_word = {chk_hi_q, rx_byte};

	always_comb begin
		result.hit  = (pos_q == POS_CHK_LO) &&
			(check_word == {{(WORD_W-SUM_W){1'b0}}, sum_q});
		result.pm25 = pm25_q;
		result.pm10 = pm10_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			pm25_q   <= '0;
			pm10_q   <= '0;
			chk_hi_q <= '0;
		end else if (fire) begin
			if (pos_q == 5'd0) begin
				if (rx_byte == HDR_FIRST) begin
					pos_q <= 5'd1;
					sum_q <= {{(SUM_W-8){1'b0}}, rx_byte};
				end else begin
					pos_q <= '0;
					sum_q <= '0;
				end
			end else if (pos_q == 5'd1) begin
				if (rx_byte == HDR_SECOND) begin
					pos_q <= 5'd2;
					sum_q <= sum_add;
				end else begin
					pos_q <= '0;
					sum_q <= '0;
				end
			end else if (pos_q < POS_CHK_HI) begin
				sum_q <= sum_add;
				pos_q <= pos_q + 5'd1;
				case (pos_q)
					POS_PM25_HI: pm25_q[15:8] <= rx_byte;
					POS_PM25_LO: pm25_q[7:0]  <= rx_byte;
					POS_PM10_HI: pm10_q[15:8] <= rx_byte;
					POS_PM10_LO: pm10_q[7:0]  <= rx_byte;
					default: ;
				endcase
			end else if (pos_q == POS_CHK_HI) begin
				chk_hi_q <= rx_byte;
				pos_q    <= POS_CHK_LO;
			end else begin
				pos_q <= '0;
				sum_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/psfp_out_reg.sv]
`default_nettype none

module psfp_out_reg
	import psfp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic [2*WORD_W-1:0] load_data,
	output logic                     free,
	output logic                     tvalid,
	input  wire logic                tready,
	output logic [2*WORD_W-1:0]      tdata
);

	logic                valid_q;
	logic [2*WORD_W-1:0] data_q;

	assign free   = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

[hdl/particle_sensor_frame_parser.sv]
// Particle sensor frame parser.
// Slave stream (s_tvalid/s_tready/s_tdata) carries one received serial byte per
// transaction. Master stream (m_tvalid/m_tready/m_tdata) carries one
// transaction for every 32-byte frame that starts with 0x42 0x4D and whose
// check word in bytes 30 and 31 equals the sum of bytes 0 to 29.
// The transaction carries the PM2.5 word (bytes 12 and 13) and the PM10
// word (bytes 14 and 15); bad frames produce nothing and the hunt restarts.
// Throughput is one byte per cycle while no byte that completes a good
// frame waits for the output register. A byte lands in an input register,
// the parser state is updated from that register, and the result is
// registered in the output register that drives m_tvalid and m_tdata.
// When the receiver stalls, the result waits in the output register and
// bytes that produce no result keep flowing; only a byte that completes
// a good frame waits until the output register is taken.
// Reset clears the hunt position, the running sum and both valid flags.

`default_nettype none

module particle_sensor_frame_parser
	import psfp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,  // [7:0] rx_byte
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [2*WORD_W-1:0]      m_tdata   // [15:0] pm25_reading, [31:16] pm10_reading
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         proc_fire;
	psfp_result_t result;

	assign proc_fire = valid_s1 && (!result.hit || out_free);
	assign s_tready  = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	psfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (proc_fire),
		.rx_byte (byte_s1),
		.result  (result)
	);

	psfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (proc_fire && result.hit),
		.load_data ({result.pm10, result.pm25}),
		.free      (out_free),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.tdata     (m_tdata)
	);

endmodule

`default_nettype wire

[hdl/psfp_checker.sv]
`default_nettype none

module psfp_checker
	import psfp_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [7:0]          s_tdata,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [2*WORD_W-1:0] m_tdata
);

	// A stalled input transaction keeps its byte until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input byte changed while stalled");

	// A stalled result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the output register empty, input is never back-pressured.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// A result must follow either an accepted byte or a stall of the input.
	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 2))
		else $error("result without a completing byte");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
